// ----- rtl/bdq_pkg.sv -----
// Package for the bounded deque: operation and status codes, cell control type.
// No dependencies; used by bdq_cell and bounded_deque_remove_by_value.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    // Field widths
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;
    localparam int OUT_W    = 80;

    // Operation codes (input kind)
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE_FIRST = 3'd4;
    localparam logic [KIND_W-1:0] KIND_REMOVE_ALL   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_EXISTS       = 3'd6;
    localparam logic [KIND_W-1:0] KIND_CLEAR        = 3'd7;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // Cell move codes
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_SHL  = 2'd1;  // take right neighbor (toward front)
    localparam logic [1:0] CELL_SHR  = 2'd2;  // take left neighbor (toward back)

    // Control broadcast to every cell
    typedef struct packed {
        logic [1:0] move;
        logic       wr_en;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/bdq_cell.sv -----
// One storage cell of the deque chain: holds one entry, shifts to/from neighbors.
// Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_cell #(
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  wire                        i_clk,
    input  bdq_pkg::t_cell_ctl         i_ctl,
    input  wire [IW-1:0]               i_wr_idx,
    input  wire [bdq_pkg::DATA_W-1:0]  i_wr_data,
    input  wire [bdq_pkg::DATA_W-1:0]  i_left,
    input  wire [bdq_pkg::DATA_W-1:0]  i_right,
    input  wire                        i_back_en,
    input  wire [IW-1:0]               i_back_idx,
    output logic [bdq_pkg::DATA_W-1:0] o_data,
    output logic [bdq_pkg::DATA_W-1:0] o_back
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [bdq_pkg::DATA_W-1:0] r_data;
    logic [bdq_pkg::DATA_W-1:0] n_data;

    // Directed write wins over the shift
    always_comb begin
        n_data = r_data;
        case (i_ctl.move)
            bdq_pkg::CELL_SHL: n_data = i_right;
            bdq_pkg::CELL_SHR: n_data = i_left;
            default:           n_data = r_data;
        endcase
        if (i_ctl.wr_en && (i_wr_idx == MY_IDX)) begin
            n_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Contributes to the back-value OR tree only when this cell is the last entry
    assign o_back = (i_back_en && (i_back_idx == MY_IDX)) ? r_data : '0;

endmodule

`default_nettype wire

// ----- rtl/bounded_deque_remove_by_value.sv -----
// Bounded double-ended queue of signed 32-bit values built as a row of shift cells.
// Depends on bdq_pkg and bdq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Bounded deque with remove-by-value. Each transfer on the slave side carries one
// operation (kind in tuser, value in tdata) and yields exactly one result transfer.
// Push, pop and clear pass through an execute step and then a step that loads the
// result register. Remove first, remove all and exists pass through a setup step,
// a walk in which the whole row rotates through the comparator at cell 0 once,
// visiting each held entry, a step to close the walk and one to load the result
// register. Kept entries are written back behind the unvisited ones, so order is
// preserved. A result that still waits on the master side holds the engine in its
// last step until that transfer completes. A new operation is accepted whenever
// the engine is idle, even while a previous result waits on the master side.
// Entries carry no reset; only positions below the count are read.

module bounded_deque_remove_by_value #(
    parameter int CAPACITY = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] value
    input  wire  [2:0]  s_axis_tuser,   // [2:0] kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [79:0] m_axis_tdata    // [1:0] status, [2] found, [7:3] removed_count,
                                        // [12:8] size_after, [44:13] front_value,
                                        // [76:45] back_value, [79:77] zero
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                          r_state, n_state;
    logic [bdq_pkg::KIND_W-1:0]          r_kind, n_kind;
    logic [bdq_pkg::DATA_W-1:0]          r_value, n_value;
    logic [CW-1:0]                       r_count, n_count;
    logic [CW-1:0]                       r_left, n_left;
    logic [CW-1:0]                       r_kept, n_kept;
    logic [CW-1:0]                       r_removed, n_removed;
    logic                                r_found, n_found;
    logic [bdq_pkg::STATUS_W-1:0]        r_status, n_status;
    logic                                r_mvalid, n_mvalid;
    logic [bdq_pkg::OUT_W-1:0]           r_mdata, n_mdata;

    bdq_pkg::t_cell_ctl                  w_ctl;
    logic [IW-1:0]                       w_wr_idx;
    logic [bdq_pkg::DATA_W-1:0]          w_wr_data;
    logic [bdq_pkg::DATA_W-1:0]          w_data [CAPACITY];
    logic [bdq_pkg::DATA_W-1:0]          w_back [CAPACITY];
    logic [bdq_pkg::DATA_W-1:0]          w_back_val;
    logic [bdq_pkg::DATA_W-1:0]          w_front_val;
    logic [IW-1:0]                       w_back_idx;
    logic                                w_nonempty;
    logic [CW-1:0]                       w_walk_pos;
    logic                                w_match;
    logic                                w_keep;
    logic                                w_accept;
    logic [31:0]                         w_removed32;
    logic [31:0]                         w_count32;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    // Row of cells
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [bdq_pkg::DATA_W-1:0] w_left;
            logic [bdq_pkg::DATA_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = w_wr_data;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_data[g];
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            bdq_cell #(
                .IW  (IW),
                .IDX (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_wr_idx   (w_wr_idx),
                .i_wr_data  (w_wr_data),
                .i_left     (w_left),
                .i_right    (w_right),
                .i_back_en  (w_nonempty),
                .i_back_idx (w_back_idx),
                .o_data     (w_data[g]),
                .o_back     (w_back[g])
            );
        end
    endgenerate

    // Front and back of the current contents
    assign w_nonempty  = (r_count != '0);
    assign w_back_idx  = IW'(r_count - ONE_C);
    assign w_front_val = w_nonempty ? w_data[0] : '0;

    always_comb begin
        w_back_val = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_back_val = w_back_val | w_back[k];
        end
    end

    // Walk step: head entry leaves cell 0, kept entries land behind the unvisited ones
    assign w_walk_pos = r_left + r_kept - ONE_C;
    assign w_match    = (w_data[0] == r_value);
    assign w_keep     = (r_kind == bdq_pkg::KIND_EXISTS) || !w_match ||
                        ((r_kind == bdq_pkg::KIND_REMOVE_FIRST) && r_found);

    assign w_removed32 = 32'(r_removed);
    assign w_count32   = 32'(r_count);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_value   = r_value;
        n_count   = r_count;
        n_left    = r_left;
        n_kept    = r_kept;
        n_removed = r_removed;
        n_found   = r_found;
        n_status  = r_status;
        n_mvalid  = r_mvalid;
        n_mdata   = r_mdata;
        w_ctl     = '{move: bdq_pkg::CELL_HOLD, wr_en: 1'b0};
        w_wr_idx  = '0;
        w_wr_data = r_value;

        if (r_mvalid && m_axis_tready) begin
            n_mvalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind  = s_axis_tuser;
                    n_value = s_axis_tdata;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status  = bdq_pkg::ST_OK;
                n_found   = 1'b0;
                n_removed = '0;
                n_state   = S_DONE;
                case (r_kind)
                    bdq_pkg::KIND_PUSH_FRONT: begin
                        if (r_count >= CAP_C) begin
                            n_status = bdq_pkg::ST_FULL;
                        end else begin
                            w_ctl    = '{move: bdq_pkg::CELL_SHR, wr_en: 1'b1};
                            w_wr_idx = '0;
                            n_count  = r_count + ONE_C;
                        end
                    end
                    bdq_pkg::KIND_PUSH_BACK: begin
                        if (r_count >= CAP_C) begin
                            n_status = bdq_pkg::ST_FULL;
                        end else begin
                            w_ctl    = '{move: bdq_pkg::CELL_HOLD, wr_en: 1'b1};
                            w_wr_idx = IW'(r_count);
                            n_count  = r_count + ONE_C;
                        end
                    end
                    bdq_pkg::KIND_POP_FRONT: begin
                        if (!w_nonempty) begin
                            n_status = bdq_pkg::ST_EMPTY;
                        end else begin
                            w_ctl     = '{move: bdq_pkg::CELL_SHL, wr_en: 1'b0};
                            n_count   = r_count - ONE_C;
                            n_removed = ONE_C;
                        end
                    end
                    bdq_pkg::KIND_POP_BACK: begin
                        if (!w_nonempty) begin
                            n_status = bdq_pkg::ST_EMPTY;
                        end else begin
                            n_count   = r_count - ONE_C;
                            n_removed = ONE_C;
                        end
                    end
                    bdq_pkg::KIND_REMOVE_FIRST,
                    bdq_pkg::KIND_REMOVE_ALL,
                    bdq_pkg::KIND_EXISTS: begin
                        n_left  = r_count;
                        n_kept  = '0;
                        n_state = S_WALK;
                    end
                    default: begin
                        // clear
                        n_removed = r_count;
                        n_count   = '0;
                    end
                endcase
            end
            S_WALK: begin
                if (r_left == '0) begin
                    n_count  = r_kept;
                    n_status = r_found ? bdq_pkg::ST_OK : bdq_pkg::ST_NOTFOUND;
                    n_state  = S_DONE;
                end else begin
                    w_ctl     = '{move: bdq_pkg::CELL_SHL, wr_en: w_keep};
                    w_wr_idx  = w_walk_pos[IW-1:0];
                    w_wr_data = w_data[0];
                    n_left    = r_left - ONE_C;
                    if (w_keep) begin
                        n_kept = r_kept + ONE_C;
                    end else begin
                        n_removed = r_removed + ONE_C;
                    end
                    if (w_match) begin
                        n_found = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_mvalid || m_axis_tready) begin
                    n_mdata  = {3'b000, w_back_val, w_front_val, w_count32[4:0],
                                w_removed32[4:0], r_found, r_status};
                    n_mvalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_mvalid <= n_mvalid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_value   <= n_value;
        r_left    <= n_left;
        r_kept    <= n_kept;
        r_removed <= n_removed;
        r_found   <= n_found;
        r_status  <= n_status;
        r_mdata   <= n_mdata;
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((32'(r_left) + 32'(r_kept)) <= 32'(r_count)))
        else $error("walk pointers exceed held entries");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted operation did not start");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !r_mvalid) |=> (r_mvalid && (r_state == S_IDLE)))
        else $error("finished operation did not post a result");

    a_walk_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) && (r_kind == bdq_pkg::KIND_REMOVE_FIRST)) |->
        (r_removed <= ONE_C))
        else $error("remove first dropped more than one entry");

endmodule

`default_nettype wire
